FILE: rtl/run_length_escape_encoder_assert.svh
// Assertion macros used by the run-length escape encoder request queue.
`ifndef RUN_LENGTH_ESCAPE_ENCODER_ASSERT_SVH
`define RUN_LENGTH_ESCAPE_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLEE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RLEE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rlee_pkg.sv
// Package with the types, constants and command builder of the run-length escape encoder.
package rlee_pkg;

	localparam logic [7:0] ESC_BYTE      = 8'h5C;
	localparam logic [7:0] ASCII_ZERO    = 8'h30;
	localparam logic [7:0] TERM_BYTE     = 8'h00;
	localparam logic [6:0] MAX_RUN       = 7'd99;
	localparam logic [3:0] MIN_RUN_LOW   = 4'd2;
	localparam logic [3:0] MIN_RUN_HIGH  = 4'd9;
	localparam logic [3:0] MIN_RUN_RESET = 4'd4;
	localparam logic [6:0] TWO_DIGITS    = 7'd10;

	// One flush request passed from the front to the back.
	typedef struct packed {
		logic [7:0] sym;       // byte of the run
		logic [3:0] body_n;    // bytes before the optional terminator
		logic       esc;       // escaped count form
		logic       has_tens;  // count takes two digits
		logic [7:0] tens_ch;   // ASCII tens digit
		logic [7:0] ones_ch;   // ASCII ones digit
		logic       term;      // append the zero terminator
	} cmd_t;

	// Builds the flush request for a run of len bytes.
	function automatic cmd_t make_cmd(input logic [7:0] sym, input logic [6:0] len,
			input logic [3:0] eff_min, input logic term);
		cmd_t        c;
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  rem;
		// Tens digit by reciprocal multiply; exact for all lengths up to 99.
		prod       = {8'b0, len} * 15'd205;
		tens       = prod[14:11];
		rem        = len - 7'({3'b0, tens} * 7'd10);
		c.sym      = sym;
		c.term     = term;
		c.esc      = (len >= {3'b0, eff_min});
		c.has_tens = (len >= TWO_DIGITS);
		c.tens_ch  = ASCII_ZERO | {4'b0, tens};
		c.ones_ch  = ASCII_ZERO | {4'b0, rem[3:0]};
		if (!c.esc) begin
			c.body_n = len[3:0];
		end else if (c.has_tens) begin
			c.body_n = 4'd4;
		end else begin
			c.body_n = 4'd3;
		end
		return c;
	endfunction

endpackage

FILE: rtl/rlee_front.sv
// Front part: tracks the pending run and issues one flush request per item at most.
module rlee_front import rlee_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] symbol,
	input  logic       end_marker,
	input  logic [3:0] min_run,
	output logic       cmd_push,
	output cmd_t       cmd
);

	logic [7:0] run_byte_q;
	logic [6:0] run_length_q;
	logic       run_open_q;
	logic [3:0] eff_min;
	logic       extend;
	logic [6:0] ext_len;
	logic [6:0] flush_len;

	// Clamp the configured threshold into its meaningful range.
	always_comb begin
		if (min_run < MIN_RUN_LOW) begin
			eff_min = MIN_RUN_LOW;
		end else if (min_run > MIN_RUN_HIGH) begin
			eff_min = MIN_RUN_HIGH;
		end else begin
			eff_min = min_run;
		end
	end

	assign extend    = run_open_q && (symbol == run_byte_q);
	assign ext_len   = run_length_q + 7'd1;
	assign flush_len = run_open_q ? run_length_q : 7'd0;

	// Classify the item: end flush, saturated run, run break, or plain extension.
	always_comb begin
		cmd_push = 1'b0;
		cmd      = make_cmd(run_byte_q, flush_len, eff_min, 1'b0);
		if (accept) begin
			if (end_marker) begin
				cmd_push = 1'b1;
				cmd      = make_cmd(run_byte_q, flush_len, eff_min, 1'b1);
			end else if (extend) begin
				cmd_push = (ext_len >= MAX_RUN);
				cmd      = make_cmd(run_byte_q, ext_len, eff_min, 1'b0);
			end else begin
				cmd_push = run_open_q;
			end
		end
	end

	// Run state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_byte_q   <= '0;
			run_length_q <= '0;
			run_open_q   <= 1'b0;
		end else if (accept) begin
			if (end_marker) begin
				run_byte_q   <= '0;
				run_length_q <= '0;
				run_open_q   <= 1'b0;
			end else if (extend) begin
				if (ext_len >= MAX_RUN) begin
					run_length_q <= '0;
					run_open_q   <= 1'b0;
				end else begin
					run_length_q <= ext_len;
				end
			end else begin
				run_byte_q   <= symbol;
				run_length_q <= 7'd1;
				run_open_q   <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/rlee_cmd_fifo.sv
// Short request queue between the front and the back.
`include "run_length_escape_encoder_assert.svh"
module rlee_cmd_fifo import rlee_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`RLEE_ASSERT_SAME(a_no_push_full, push, !full, "request pushed into a full queue")
	`RLEE_ASSERT_SAME(a_no_pop_empty, pop, !empty, "request popped from an empty queue")
	`RLEE_ASSERT_SAME(a_count_range, 1'b1, count_q <= FULL_CNT, "queue count out of range")
	`RLEE_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + CW'(1),
		"queue count did not grow on push")

endmodule

FILE: rtl/rlee_back.sv
// Back part: expands requests into bytes, one per cycle unless stalled.
module rlee_back import rlee_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic [3:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       step;
	logic [3:0] last_idx;
	logic       at_term;
	logic [7:0] sel_byte;

	assign step     = cmd_valid && (!out_valid_q || pop);
	assign last_idx = cmd.term ? cmd.body_n : cmd.body_n - 4'd1;
	assign at_term  = (idx_q == cmd.body_n);
	assign cmd_pop  = step && (idx_q == last_idx);

	// Pick the byte for the current position within the request.
	always_comb begin
		priority if (at_term) begin
			sel_byte = TERM_BYTE;
		end else if (!cmd.esc) begin
			sel_byte = cmd.sym;
		end else if (idx_q == 4'd0) begin
			sel_byte = ESC_BYTE;
		end else if (cmd.has_tens && idx_q == 4'd1) begin
			sel_byte = cmd.tens_ch;
		end else if (idx_q == (cmd.has_tens ? 4'd2 : 4'd1)) begin
			sel_byte = cmd.ones_ch;
		end else begin
			sel_byte = cmd.sym;
		end
	end

	// Position counter within the current request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (step) begin
			idx_q <= cmd_pop ? 4'd0 : idx_q + 4'd1;
		end
	end

	// Output register; it frees as soon as its byte is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q <= sel_byte;
			out_last_q <= cmd.term && at_term;
		end
	end

	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

endmodule

FILE: rtl/run_length_escape_encoder.sv
// Top level of the run-length escape encoder: register port, front, queue and back.
//
// Channel   Direction  Handshake            Payload
// input     in         push / full          symbol, end_marker
// result    out        pop / empty          out_byte, out_last
// config    in         psel/penable/pwrite  paddr, pwdata, prdata (min_run)
//
// One input byte is taken every cycle while the request queue has room.
// The back emits one result byte per cycle while the result side keeps popping.
// A flush request is queued first; its bytes leave through the output register.
// Reset clears the run state, the queue and the output register; min_run resets to 4.
// A stalled result side fills the queue, and full then holds off the input.
module run_length_escape_encoder import rlee_pkg::*; #(
	parameter int CMD_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  symbol,
	input  logic        end_marker,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        out_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [3:0] min_run_q;
	logic       accept;
	logic       cmd_push;
	cmd_t       push_cmd;
	cmd_t       head_cmd;
	logic       cmd_empty;
	logic       cmd_pop;

	// Register port: the single register answers at every word address.
	assign pready = 1'b1;
	assign prdata = {28'b0, min_run_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_run_q <= MIN_RUN_RESET;
		end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
			min_run_q <= pwdata[3:0];
		end else if (psel && penable && pwrite && pready) begin
			min_run_q <= pwdata[3:0];
		end
	end

	assign accept = push && !full;

	rlee_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.symbol     (symbol),
		.end_marker (end_marker),
		.min_run    (min_run_q),
		.cmd_push   (cmd_push),
		.cmd        (push_cmd)
	);

	rlee_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (cmd_pop),
		.head     (head_cmd),
		.empty    (cmd_empty)
	);

	rlee_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule
